/* sv/assert_macros.svh */
// assertion macros shared by the framer rtl
// no dependencies; pulled in by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lpf_pkg.sv */
// shared types, constants and helpers for the lrc packet framer
// no dependencies; used by every module of the block
package lpf_pkg;

    localparam int unsigned MAX_WORDS   = 4;
    localparam int unsigned CMDQ_DEPTH  = 2;
    localparam int unsigned CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    // byte positions inside one run of the back end
    localparam logic [3:0] STEP_BODY_LAST = 4'd7;
    localparam logic [3:0] STEP_LRC       = 4'd8;
    localparam logic [3:0] STEP_LRC_INV   = 4'd9;
    localparam logic [3:0] STEP_FC        = 4'd5;
    localparam logic [3:0] STEP_SC        = 4'd6;

    typedef struct packed {
        logic        mode;
        logic [7:0]  function_code;
        logic [7:0]  sub_code;
        logic [2:0]  data_count;
        logic [63:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_packet;
        logic       error;
    } out_item_t;

    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_HDR  = 2'd0;
    localparam cmd_kind_t CMD_DATA = 2'd1;
    localparam cmd_kind_t CMD_ERR  = 2'd2;

    // header payload packs fc, sc and count into the low bits
    typedef struct packed {
        cmd_kind_t   kind;
        logic        trailer;
        logic [63:0] payload;
    } cmd_t;

    function automatic logic [7:0] sync_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'hE1;
            3'd2:    b = 8'h69;
            3'd3:    b = 8'hA5;
            3'd4:    b = 8'h3C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* sv/lpf_front.sv */
// front end: accepts items, tracks packet state and classifies each item
// depends on lpf_pkg
module lpf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpf_pkg::in_item_t in_item,
    input  logic              cmdq_full,
    output logic              full,
    output logic              cmd_valid,
    output lpf_pkg::cmd_t     cmd
);

    logic       open_reg, open_next;
    logic [2:0] words_left_reg, words_left_next;

    assign full      = cmdq_full;
    assign cmd_valid = push && !cmdq_full;

    always_comb
    begin
        cmd.kind        = lpf_pkg::CMD_ERR;
        cmd.trailer     = 1'b0;
        cmd.payload     = in_item.data_word;
        open_next       = open_reg;
        words_left_next = words_left_reg;
        if (!in_item.mode)
        begin
            cmd.payload = {45'd0, in_item.function_code, in_item.sub_code,
                           in_item.data_count};
            if (in_item.data_count > 3'(lpf_pkg::MAX_WORDS))
            begin
                open_next       = 1'b0;
                words_left_next = 3'd0;
            end
            else
            begin
                cmd.kind        = lpf_pkg::CMD_HDR;
                cmd.trailer     = (in_item.data_count == 3'd0);
                open_next       = (in_item.data_count != 3'd0);
                words_left_next = in_item.data_count;
            end
        end
        else if (open_reg)
        begin
            cmd.kind        = lpf_pkg::CMD_DATA;
            cmd.trailer     = (words_left_reg == 3'd1);
            open_next       = (words_left_reg != 3'd1);
            words_left_next = words_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            words_left_reg <= 3'd0;
        end
        else if (cmd_valid)
        begin
            open_reg       <= open_next;
            words_left_reg <= words_left_next;
        end
    end

endmodule

/* sv/lpf_cmd_fifo.sv */
// short command queue between the front and back ends
// depends on lpf_pkg
module lpf_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lpf_pkg::cmd_t wr_cmd,
    input  logic          rd_en,
    output lpf_pkg::cmd_t rd_cmd,
    output logic          full,
    output logic          empty
);

    lpf_pkg::cmd_t entries [lpf_pkg::CMDQ_DEPTH];

    logic [lpf_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [lpf_pkg::CMDQ_CNT_W-1:0] count_reg;

    assign full   = (count_reg == lpf_pkg::CMDQ_CNT_W'(lpf_pkg::CMDQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = entries[rd_ptr_reg];

    function automatic logic [lpf_pkg::CMDQ_PTR_W-1:0] ptr_inc(
        input logic [lpf_pkg::CMDQ_PTR_W-1:0] p);
        logic [lpf_pkg::CMDQ_PTR_W-1:0] r;
        if (p == lpf_pkg::CMDQ_PTR_W'(lpf_pkg::CMDQ_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (rd_en)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* sv/lpf_back.sv */
// back end: byte sequencer, running lrc and output register
// depends on lpf_pkg
module lpf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  lpf_pkg::cmd_t      cmd,
    output logic               cmd_take,
    input  logic               pop,
    output logic               empty,
    output lpf_pkg::out_item_t out_item,
    output logic               busy
);

    lpf_pkg::cmd_t      cmd_reg;
    logic               busy_reg;
    logic [3:0]         step_reg;
    logic [7:0]         lrc_reg;
    logic               out_valid_reg;
    lpf_pkg::out_item_t out_item_reg;

    logic               advance;
    logic               last_step;
    logic [7:0]         lrc_base;
    logic [7:0]         body_byte;
    lpf_pkg::out_item_t result;

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;
    assign busy     = busy_reg;

    assign advance  = busy_reg && (!out_valid_reg || pop);
    assign cmd_take = cmd_valid && (!busy_reg || (advance && last_step));

    always_comb
    begin
        if (cmd_reg.kind == lpf_pkg::CMD_ERR)
            last_step = 1'b1;
        else if (cmd_reg.trailer)
            last_step = (step_reg == lpf_pkg::STEP_LRC_INV);
        else
            last_step = (step_reg == lpf_pkg::STEP_BODY_LAST);
    end

    // a header restarts the checksum on its first sync byte
    assign lrc_base = (cmd_reg.kind == lpf_pkg::CMD_HDR && step_reg == 4'd0) ? 8'h00 : lrc_reg;

    always_comb
    begin
        unique case (cmd_reg.kind)
            lpf_pkg::CMD_HDR:
            begin
                if (step_reg == lpf_pkg::STEP_FC)
                    body_byte = cmd_reg.payload[18:11];
                else if (step_reg == lpf_pkg::STEP_SC)
                    body_byte = cmd_reg.payload[10:3];
                else if (step_reg == lpf_pkg::STEP_BODY_LAST)
                    body_byte = {5'd0, cmd_reg.payload[2:0]};
                else
                    body_byte = lpf_pkg::sync_byte(step_reg[2:0]);
            end
            lpf_pkg::CMD_DATA:
                body_byte = cmd_reg.payload[{step_reg[2:0], 3'b000} +: 8];
            default:
                body_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        result.error         = (cmd_reg.kind == lpf_pkg::CMD_ERR);
        result.last_of_run   = last_step;
        result.end_of_packet = (step_reg == lpf_pkg::STEP_LRC_INV);
        if (result.error)
            result.out_byte = 8'h00;
        else if (step_reg == lpf_pkg::STEP_LRC)
            result.out_byte = lrc_reg;
        else if (step_reg == lpf_pkg::STEP_LRC_INV)
            result.out_byte = ~lrc_reg;
        else
            result.out_byte = body_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            cmd_reg <= cmd;
        if (advance)
            out_item_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 4'd0;
            lrc_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;

            if (advance && step_reg <= lpf_pkg::STEP_BODY_LAST)
                lrc_reg <= lrc_base ^ body_byte;

            if (cmd_take)
            begin
                busy_reg <= 1'b1;
                step_reg <= 4'd0;
            end
            else if (advance)
            begin
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= 4'd0;
                end
                else
                    step_reg <= step_reg + 4'd1;
            end
        end
    end

endmodule

/* sv/lrc_packet_framer_core.sv */
// lrc packet framer top level: front end, command queue and back end
// depends on lpf_pkg, lpf_front, lpf_cmd_fifo, lpf_back and assert_macros.svh
//
// usage
//   input side is a queue: drive in_item and raise push; the item is taken at
//   an edge where push is high and full is low. mode 0 is a header item,
//   mode 1 a data word item
//   result side is a queue too: while empty is low the oldest byte result is
//   on out_item; it is taken at an edge where pop is high and empty is low
//   from an idle block the item passes into the command queue, then into the
//   sequencer, and its first result then goes into the output register
//   throughput: one result byte per cycle while the receiver keeps popping,
//   set by the single output register behind the byte sequencer. a data item
//   gives 8 bytes, 10 when it closes the packet with the lrc pair; a header 8
//   or 10; an error item 1. a loaded sequencer takes the next queued item as
//   the last byte of the current one goes out. the two-entry command queue
//   lets items be taken while the back end is still sending, so full only
//   rises once two items are waiting. when the receiver stalls the output
//   register holds its byte, the sequencer stops, then the queue fills and full rises
//   reset clears the packet state, the queue and the output valid flag; no
//   packet is open after reset
`include "assert_macros.svh"

module lrc_packet_framer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lpf_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output lpf_pkg::out_item_t out_item
);

    // front to queue
    logic          front_cmd_valid;
    lpf_pkg::cmd_t front_cmd;
    logic          cmdq_full;

    // queue to back
    lpf_pkg::cmd_t cmdq_rd_cmd;
    logic          cmdq_empty;
    logic          back_take;
    logic          back_busy;

    // classification needs the open packet state, so it lives at the front
    lpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .cmdq_full (cmdq_full),
        .full      (full),
        .cmd_valid (front_cmd_valid),
        .cmd       (front_cmd)
    );

    lpf_cmd_fifo u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_cmd_valid),
        .wr_cmd (front_cmd),
        .rd_en  (back_take),
        .rd_cmd (cmdq_rd_cmd),
        .full   (cmdq_full),
        .empty  (cmdq_empty)
    );

    // back end owns the running lrc, as only it sees bytes in order
    lpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmdq_empty),
        .cmd       (cmdq_rd_cmd),
        .cmd_take  (back_take),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item),
        .busy      (back_busy)
    );

    // closing byte always ends its run and is never an error
    `ASSERT_IMPLIES(a_eop_ends_run, clk, rst_n, !empty && out_item.end_of_packet,
        out_item.last_of_run && !out_item.error, "end of packet without end of run")
    // an error is a lone zero byte
    `ASSERT_IMPLIES(a_err_single, clk, rst_n, !empty && out_item.error,
        out_item.last_of_run && out_item.out_byte == 8'h00 && !out_item.end_of_packet,
        "malformed error result")
    // an accepted item is held in the queue on the next cycle
    `ASSERT_NEXT(a_item_queued, clk, rst_n, push && !full,
        !cmdq_empty, "accepted item lost")
    // an idle sequencer never leaves a queued command waiting
    `ASSERT_IMPLIES(a_idle_takes, clk, rst_n, !cmdq_empty && !back_busy,
        back_take, "idle back end left a command waiting")

endmodule
